/* design/ethernet_header_extractor_defines.svh */
// Assertion macros shared by the header extractor checker.
`ifndef ETHERNET_HEADER_EXTRACTOR_DEFINES_SVH
`define ETHERNET_HEADER_EXTRACTOR_DEFINES_SVH

// Check a property on every rising edge, idle while reset is asserted.
`define EHX_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge.
`define EHX_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

/* design/ethhdr_pkg.sv */
// Types and constants of the Ethernet header extractor.
`default_nettype none

package ethhdr_pkg;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_TYPE    = 3'd2,
		ST_TAG_SHORT   = 3'd3,
		ST_NO_PAYLOAD  = 3'd4
	} status_t;

	typedef logic [4:0] count_t;

	// Byte positions where each header field ends.
	localparam count_t DST_END   = 5'd6;
	localparam count_t SRC_END   = 5'd12;
	localparam count_t TYPE_END  = 5'd14;
	localparam count_t TCI_END   = 5'd16;
	localparam count_t INNER_END = 5'd18;
	localparam count_t COUNT_MAX = 5'd19;

	localparam count_t OFFSET_UNTAGGED = 5'd14;
	localparam count_t OFFSET_TAGGED   = 5'd18;

	localparam logic [15:0] TPID_8021Q = 16'h8100;
	localparam logic [15:0] LEN_MAX    = 16'd1500;
	localparam logic [15:0] TYPE_MIN   = 16'h0600;

	localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

endpackage

`default_nettype wire

/* design/ethernet_header_extractor.sv */
// Ethernet II header extractor with optional single 802.1Q tag.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  in       | in_valid/in_stall  | data_byte, last_byte
//  out      | out_valid/out_stall| status, dst_mac ... payload_offset
//  config   | cfg_we             | cfg_wdata (vlan_enable)
//
// One byte is taken per cycle unless the input stalls; the result appears in the next cycle.
// The field registers capture in the accept cycle; the output register holds
// the result until taken, and the input stalls only while it is held.
// Reset clears the byte count and output valid and sets vlan_enable to 1.
`default_nettype none

module ethernet_header_extractor (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          data_byte,
	input  wire logic                last_byte,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ethhdr_pkg::status_t      status,
	output logic [47:0]              dst_mac,
	output logic [47:0]              src_mac,
	output logic [15:0]              outer_type,
	output logic                     vlan_present,
	output logic [15:0]              vlan_tci,
	output logic [15:0]              next_type,
	output logic                     dst_bcast,
	output logic                     dst_mcast,
	output logic [4:0]               payload_offset
);
	import ethhdr_pkg::*;

	logic        vlan_en_q;
	count_t      byte_cnt_q;
	logic [47:0] dst_q, src_q;
	logic [15:0] type_q, tci_q, inner_q;

	logic [47:0] dst_nx, src_nx;
	logic [15:0] type_nx, tci_nx, inner_nx;
	count_t      size;

	status_t     res_status;
	logic        hdr_ok, res_vp;
	logic [15:0] res_tci, res_np;
	count_t      res_off;

	logic        out_valid_q;
	logic        in_acc, out_ld;

	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;
	assign out_ld    = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;

	// Shift the byte into the field that owns its position.
	always_comb begin
		dst_nx   = dst_q;
		src_nx   = src_q;
		type_nx  = type_q;
		tci_nx   = tci_q;
		inner_nx = inner_q;
		if (byte_cnt_q < DST_END) begin
			dst_nx = {dst_q[39:0], data_byte};
		end else if (byte_cnt_q < SRC_END) begin
			src_nx = {src_q[39:0], data_byte};
		end else if (byte_cnt_q < TYPE_END) begin
			type_nx = {type_q[7:0], data_byte};
		end else if (byte_cnt_q < TCI_END) begin
			tci_nx = {tci_q[7:0], data_byte};
		end else if (byte_cnt_q < INNER_END) begin
			inner_nx = {inner_q[7:0], data_byte};
		end
		size = (byte_cnt_q < COUNT_MAX) ? byte_cnt_q + 5'd1 : COUNT_MAX;
	end

	// Classify the frame from the values as they stand after this byte.
	always_comb begin
		res_status = ST_OK;
		hdr_ok     = 1'b0;
		res_vp     = 1'b0;
		res_tci    = '0;
		res_np     = '0;
		res_off    = '0;
		if (size < TYPE_END) begin
			res_status = ST_TOO_SHORT;
		end else begin
			hdr_ok = 1'b1;
			if (type_nx > LEN_MAX && type_nx < TYPE_MIN) begin
				res_status = ST_BAD_TYPE;
			end else if (vlan_en_q && type_nx == TPID_8021Q) begin
				if (size < INNER_END) begin
					res_status = ST_TAG_SHORT;
				end else begin
					res_vp     = 1'b1;
					res_tci    = tci_nx;
					res_np     = inner_nx;
					res_off    = OFFSET_TAGGED;
					res_status = (size <= OFFSET_TAGGED) ? ST_NO_PAYLOAD : ST_OK;
				end
			end else begin
				res_np     = type_nx;
				res_off    = OFFSET_UNTAGGED;
				res_status = (size <= OFFSET_UNTAGGED) ? ST_NO_PAYLOAD : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlan_en_q <= 1'b1;
		end else if (cfg_we) begin
			vlan_en_q <= cfg_wdata;
		end
	end

	// Restart the count on the last byte; the field registers refill by shifting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
		end else if (in_acc) begin
			byte_cnt_q <= last_byte ? '0 : size;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dst_q   <= dst_nx;
			src_q   <= src_nx;
			type_q  <= type_nx;
			tci_q   <= tci_nx;
			inner_q <= inner_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && last_byte && out_ld) begin
			status         <= res_status;
			dst_mac        <= hdr_ok ? dst_nx : '0;
			src_mac        <= hdr_ok ? src_nx : '0;
			outer_type     <= hdr_ok ? type_nx : '0;
			vlan_present   <= res_vp;
			vlan_tci       <= res_tci;
			next_type      <= res_np;
			dst_bcast      <= hdr_ok && (dst_nx == MAC_BCAST);
			dst_mcast      <= hdr_ok && dst_nx[40];
			payload_offset <= res_off;
		end
	end

endmodule

`default_nettype wire

/* design/ethhdr_chk.sv */
// Port-level checker for the Ethernet header extractor, with its bind.
`default_nettype none
`include "ethernet_header_extractor_defines.svh"

module ethhdr_chk (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic                last_byte,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire ethhdr_pkg::status_t status,
	input  wire logic [47:0]         dst_mac,
	input  wire logic                vlan_present,
	input  wire logic                dst_bcast,
	input  wire logic                dst_mcast,
	input  wire logic [4:0]          payload_offset
);
	import ethhdr_pkg::*;

	`EHX_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
	`EHX_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(status) && $stable(dst_mac) && $stable(payload_offset), "stalled result changed")
	`EHX_ASSERT_NEXT(a_last_gives_result, clk, arst_n, in_valid && !in_stall && last_byte, out_valid, "last byte gave no result")
	`EHX_ASSERT(a_short_zero, clk, arst_n, out_valid && status == ST_TOO_SHORT |-> dst_mac == 48'd0 && !vlan_present && payload_offset == 5'd0, "short frame reports fields")
	`EHX_ASSERT(a_offset, clk, arst_n, out_valid && (status == ST_OK || status == ST_NO_PAYLOAD) |-> payload_offset == (vlan_present ? OFFSET_TAGGED : OFFSET_UNTAGGED) && (!dst_bcast || dst_mcast), "offset or address flags inconsistent")

endmodule

bind ethernet_header_extractor ethhdr_chk u_ethhdr_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.last_byte      (last_byte),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.status         (status),
	.dst_mac        (dst_mac),
	.vlan_present   (vlan_present),
	.dst_bcast      (dst_bcast),
	.dst_mcast      (dst_mcast),
	.payload_offset (payload_offset)
);

`default_nettype wire

/* sim/tb_ethernet_header_extractor.sv */
// Self-checking testbench for the Ethernet header extractor: random frames, handshake stress.
`timescale 1ns / 100ps

module tb_ethernet_header_extractor;
	import ethhdr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_TAIL   = 8;
	localparam int NUM_PHASES  = 6;
	localparam int PHASE_BYTES = 128;
	localparam int PHASE_FRAMES = 4;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} wire_byte_t;

	typedef struct {
		status_t     status;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] outer_type;
		logic        vlan_present;
		logic [15:0] vlan_tci;
		logic [15:0] next_type;
		logic        dst_bcast;
		logic        dst_mcast;
		logic [4:0]  payload_offset;
	} hdr_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	status_t     status;
	logic [47:0] dst_mac;
	logic [47:0] src_mac;
	logic [15:0] outer_type;
	logic        vlan_present;
	logic [15:0] vlan_tci;
	logic [15:0] next_type;
	logic        dst_bcast;
	logic        dst_mcast;
	logic [4:0]  payload_offset;

	wire_byte_t  wire_bytes[$];
	hdr_result_t expected_headers[$];

	// Header parser state as the block should hold it
	logic        vlan_on;
	count_t      hdr_count;
	logic [47:0] hdr_dst;
	logic [47:0] hdr_src;
	logic [15:0] hdr_type;
	logic [15:0] hdr_tci;
	logic [15:0] hdr_inner;

	int  send_idle_pct;
	int  recv_stall_pct;
	bit  hold_phase;
	int  hold_count;
	bit  in_taken;
	int  cycle_count;
	int  bytes_accepted;
	int  frames_checked;
	int  mismatches;
	int  tagged_frames;

	ethernet_header_extractor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.dst_mac(dst_mac),
		.src_mac(src_mac),
		.outer_type(outer_type),
		.vlan_present(vlan_present),
		.vlan_tci(vlan_tci),
		.next_type(next_type),
		.dst_bcast(dst_bcast),
		.dst_mcast(dst_mcast),
		.payload_offset(payload_offset)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_header();
		hdr_count = '0;
		hdr_dst   = '0;
		hdr_src   = '0;
		hdr_type  = '0;
		hdr_tci   = '0;
		hdr_inner = '0;
	endfunction

	// Advance the parser by one byte; return 1 when the byte closes a frame.
	function automatic bit parse_byte(input logic [7:0] b, input logic last,
			output hdr_result_t r);
		count_t size;
		r.status         = ST_OK;
		r.dst_mac        = '0;
		r.src_mac        = '0;
		r.outer_type     = '0;
		r.vlan_present   = 1'b0;
		r.vlan_tci       = '0;
		r.next_type      = '0;
		r.dst_bcast      = 1'b0;
		r.dst_mcast      = 1'b0;
		r.payload_offset = '0;
		if (hdr_count < DST_END)
			hdr_dst = {hdr_dst[39:0], b};
		else if (hdr_count < SRC_END)
			hdr_src = {hdr_src[39:0], b};
		else if (hdr_count < TYPE_END)
			hdr_type = {hdr_type[7:0], b};
		else if (hdr_count < TCI_END)
			hdr_tci = {hdr_tci[7:0], b};
		else if (hdr_count < INNER_END)
			hdr_inner = {hdr_inner[7:0], b};
		if (hdr_count < COUNT_MAX)
			hdr_count = hdr_count + 5'd1;
		if (!last)
			return 1'b0;
		size = hdr_count;
		if (size < TYPE_END) begin
			r.status = ST_TOO_SHORT;
		end else begin
			r.dst_mac    = hdr_dst;
			r.src_mac    = hdr_src;
			r.outer_type = hdr_type;
			r.dst_bcast  = (hdr_dst == MAC_BCAST);
			r.dst_mcast  = hdr_dst[40];
			if (hdr_type > LEN_MAX && hdr_type < TYPE_MIN) begin
				r.status = ST_BAD_TYPE;
			end else if (vlan_on && hdr_type == TPID_8021Q) begin
				if (size < INNER_END) begin
					r.status = ST_TAG_SHORT;
				end else begin
					r.vlan_present   = 1'b1;
					r.vlan_tci       = hdr_tci;
					r.next_type      = hdr_inner;
					r.payload_offset = OFFSET_TAGGED;
					r.status = (size <= OFFSET_TAGGED) ? ST_NO_PAYLOAD : ST_OK;
				end
			end else begin
				r.next_type      = hdr_type;
				r.payload_offset = OFFSET_UNTAGGED;
				r.status = (size <= OFFSET_UNTAGGED) ? ST_NO_PAYLOAD : ST_OK;
			end
		end
		clear_header();
		return 1'b1;
	endfunction

	function automatic int field_diff(input string name, input logic [47:0] exp,
			input logic [47:0] act);
		if (exp !== act) begin
			$error("%s mismatch: expected %0h, got %0h", name, exp, act);
			return 1;
		end
		return 0;
	endfunction

	// Sender: hold a stalled transaction, otherwise offer the next byte or idle.
	always @(negedge clk) begin : drive_bytes
		wire_byte_t item;
		if (arst_n && (!in_valid || in_taken)) begin
			if (wire_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item = wire_bytes.pop_front();
				in_valid  <= 1'b1;
				data_byte <= item.data;
				last_byte <= item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold-off when asked, random stalls otherwise.
	always @(negedge clk) begin
		if (hold_phase && hold_count < HOLD_CYCLES) begin
			out_stall  <= 1'b1;
			hold_count <= hold_count + 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
		if (!hold_phase)
			hold_count <= 0;
	end

	always @(posedge clk) begin : watch
		hdr_result_t r;
		hdr_result_t e;
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			bytes_accepted++;
			if (parse_byte(data_byte, last_byte, r))
				expected_headers.push_back(r);
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_headers.size() == 0) begin
				$error("result with no frame outstanding: status %0d", status);
				mismatches++;
			end else begin
				e = expected_headers.pop_front();
				frames_checked++;
				if (e.vlan_present)
					tagged_frames++;
				mismatches += field_diff("status", e.status, status);
				mismatches += field_diff("dst_mac", e.dst_mac, dst_mac);
				mismatches += field_diff("src_mac", e.src_mac, src_mac);
				mismatches += field_diff("outer_type", e.outer_type, outer_type);
				mismatches += field_diff("vlan_present", e.vlan_present, vlan_present);
				mismatches += field_diff("vlan_tci", e.vlan_tci, vlan_tci);
				mismatches += field_diff("next_type", e.next_type, next_type);
				mismatches += field_diff("dst_bcast", e.dst_bcast, dst_bcast);
				mismatches += field_diff("dst_mcast", e.dst_mcast, dst_mcast);
				mismatches += field_diff("payload_offset", e.payload_offset,
					payload_offset);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_headers.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic wait_drained();
		while (wire_bytes.size() != 0 || in_valid || expected_headers.size() != 0)
			@(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	task automatic write_vlan(input logic en);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = en;
		@(negedge clk);
		cfg_we  = 1'b0;
		vlan_on = en;
	endtask

	task automatic queue_frame(input int len, input logic [47:0] dst,
			input logic [15:0] etype);
		wire_byte_t item;
		logic [47:0] src;
		src = {$urandom, $urandom};
		for (int i = 0; i < len; i++) begin
			if (i < 6)
				item.data = dst[47 - 8 * i -: 8];
			else if (i < 12)
				item.data = src[47 - 8 * (i - 6) -: 8];
			else if (i == 12)
				item.data = etype[15:8];
			else if (i == 13)
				item.data = etype[7:0];
			else
				item.data = $urandom_range(255);
			item.last = (i == len - 1);
			wire_bytes.push_back(item);
		end
	endtask

	// Mostly well-formed headers around the interesting lengths and types.
	task automatic queue_random_frame(output int len);
		logic [47:0] dst;
		logic [15:0] etype;
		int pick;
		pick = $urandom_range(99);
		if (pick < 12)
			len = $urandom_range(13, 1);
		else if (pick < 22)
			len = 14;
		else if (pick < 32)
			len = 18;
		else if (pick < 40)
			len = $urandom_range(17, 15);
		else if (pick < 92)
			len = $urandom_range(26, 19);
		else
			len = $urandom_range(64, 27);
		pick = $urandom_range(99);
		if (pick < 35)
			etype = TPID_8021Q;
		else if (pick < 45)
			etype = 16'h0800;
		else if (pick < 50)
			etype = 16'h86DD;
		else if (pick < 60)
			etype = $urandom_range(TYPE_MIN - 1, LEN_MAX + 1);
		else if (pick < 64)
			etype = LEN_MAX;
		else if (pick < 68)
			etype = TYPE_MIN;
		else if (pick < 80)
			etype = $urandom_range(LEN_MAX, 0);
		else
			etype = $urandom_range(16'hFFFF, 0);
		pick = $urandom_range(9);
		dst = {$urandom, $urandom};
		if (pick == 0)
			dst = MAC_BCAST;
		else if (pick < 3)
			dst[40] = 1'b1;
		else if (pick < 6)
			dst[40] = 1'b0;
		queue_frame(len, dst, etype);
	endtask

	initial begin
		int len;
		int phase_bytes;
		int phase_frames;
		bit phase_vlan[NUM_PHASES];
		int phase_send[NUM_PHASES];
		int phase_recv[NUM_PHASES];
		bit phase_hold[NUM_PHASES];

		phase_vlan     = '{1, 0, 1, 0, 1, 1};
		phase_send     = '{0, 85, 0, 27, 0, 27};
		phase_recv     = '{0, 0, 85, 27, 0, 27};
		phase_hold     = '{0, 0, 0, 0, 1, 0};
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = 1'b0;
		in_valid       = 1'b0;
		data_byte      = '0;
		last_byte      = 1'b0;
		out_stall      = 1'b0;
		in_taken       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_phase     = 1'b0;
		hold_count     = 0;
		cycle_count    = 0;
		bytes_accepted = 0;
		frames_checked = 0;
		mismatches     = 0;
		tagged_frames  = 0;
		vlan_on        = 1'b1;
		clear_header();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: lone byte, broadcast with a type in the invalid gap, short tag
		queue_frame(1, 48'h0, 16'h0);
		queue_frame(14, MAC_BCAST, 16'h05FF);
		queue_frame(15, 48'h0100_5E00_00FB, TPID_8021Q);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_vlan(phase_vlan[p]);
			send_idle_pct  = phase_send[p];
			recv_stall_pct = phase_recv[p];
			hold_phase     = phase_hold[p];
			phase_bytes    = 0;
			phase_frames   = 0;
			while (phase_bytes < PHASE_BYTES || phase_frames < PHASE_FRAMES) begin
				queue_random_frame(len);
				phase_bytes += len;
				phase_frames++;
			end
			// Wait until every frame of the phase is reported before the next phase
			wait_drained();
			hold_phase = 1'b0;
		end

		$display("Checked %0d frame results (%0d tagged) from %0d bytes in %0d cycles,",
			frames_checked, tagged_frames, bytes_accepted, cycle_count);
		$display("tag parsing on and off, with sender gaps, receiver stalls and a long hold-off.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
